// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL files; the top-level decoder includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

// ===== rtl/core/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg
// Types and constants of the 24/32-bit BMP stream decoder.
// ----------------------------------------------------------------------------
package bsd_pkg;

  localparam int BSD_MAX_WIDTH  = 4096;
  localparam int BSD_MAX_HEIGHT = 4096;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;

  localparam logic [7:0]  SIG_B = 8'h42;
  localparam logic [7:0]  SIG_M = 8'h4D;

  // header byte offsets
  localparam logic [31:0] OFS_SIG_M    = 32'h0000_0001;
  localparam logic [31:0] OFS_DATA_LO  = 32'h0000_000A;
  localparam logic [31:0] OFS_DATA_HI  = 32'h0000_000D;
  localparam logic [31:0] OFS_WIDTH_LO = 32'h0000_0012;
  localparam logic [31:0] OFS_WIDTH_HI = 32'h0000_0015;
  localparam logic [31:0] OFS_HGT_LO   = 32'h0000_0016;
  localparam logic [31:0] OFS_HGT_HI   = 32'h0000_0019;
  localparam logic [31:0] OFS_BPP_LO   = 32'h0000_001C;
  localparam logic [31:0] OFS_BPP_HI   = 32'h0000_001D;
  localparam logic [31:0] MIN_DATA_OFS = 32'd30;

  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_HALT
  } bsd_phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_HEADER,
    KIND_BAD_SIG,
    KIND_UNSUPPORTED
  } bsd_kind_t;

  typedef struct packed {
    bsd_kind_t            kind;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [COORD_W-1:0]   x_coord;
    logic [COORD_W-1:0]   y_coord;
    logic [DIM_W-1:0]     width;
    logic [DIM_W-1:0]     height;
    logic                 last_pixel;
  } bsd_result_t;

endpackage

// ===== rtl/core/bsd_parser.sv =====
// ----------------------------------------------------------------------------
// bsd_parser
// Front end: walks the file bytes, gathers the header, skips to the pixel
// data and assembles pixels; one result record per byte at most.
// ----------------------------------------------------------------------------
module bsd_parser
  import bsd_pkg::*;
#(
  parameter int MAX_WIDTH  = BSD_MAX_WIDTH,
  parameter int MAX_HEIGHT = BSD_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_take,
  input  logic [7:0]  byte_data,
  input  logic        sof,
  output logic        push,
  output bsd_result_t result
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  bsd_phase_t      phase_r, phase_nxt;
  logic [31:0]     pos_r, pos_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [1:0]      bip_r, bip_nxt;
  logic [1:0]      pad_r, pad_nxt;

  logic [31:0]     ofs_r, width_r, height_r;
  logic [7:0]      bpp_lo_r;
  logic [CW-1:0]   wm1_r;
  logic [RW-1:0]   hm1_r;
  logic [1:0]      pad_fill_r;
  logic            is32_r;
  logic [7:0]      blue_r, green_r;

  logic            hdr_byte, hdr_done, pix_do, blue_we, green_we;
  logic [15:0]     bpp;
  logic            fmt_bad, last;
  logic [1:0]      lane;
  logic [RW-1:0]   y_val;

  assign hdr_byte = byte_take && !sof && (phase_r == PH_HEADER);
  assign bpp      = {byte_data, bpp_lo_r};
  assign lane     = pos_r[1:0] - 2'd2;
  assign last     = (col_r == wm1_r) && (row_r == hm1_r);
  assign y_val    = hm1_r - row_r;

  assign fmt_bad = ((bpp != BPP_24) && (bpp != BPP_32)) ||
                   (width_r == 32'd0) || (width_r > 32'(MAX_WIDTH)) ||
                   (height_r == 32'd0) || (height_r > 32'(MAX_HEIGHT)) ||
                   (ofs_r < MIN_DATA_OFS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      pos_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      bip_r   <= '0;
      pad_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      bip_r   <= bip_nxt;
      pad_r   <= pad_nxt;
    end
  end

  // header fields and pixel holding registers
  always_ff @(posedge clk) begin
    if (hdr_byte) begin
      if (pos_r >= OFS_DATA_LO && pos_r <= OFS_DATA_HI) begin
        ofs_r[8*lane +: 8] <= byte_data;
      end
      if (pos_r >= OFS_WIDTH_LO && pos_r <= OFS_WIDTH_HI) begin
        width_r[8*lane +: 8] <= byte_data;
      end
      if (pos_r >= OFS_HGT_LO && pos_r <= OFS_HGT_HI) begin
        height_r[8*lane +: 8] <= byte_data;
      end
      if (pos_r == OFS_BPP_LO) begin
        bpp_lo_r <= byte_data;
      end
    end
    if (hdr_done) begin
      wm1_r      <= CW'(width_r - 32'd1);
      hm1_r      <= RW'(height_r - 32'd1);
      is32_r     <= (bpp == BPP_32);
      pad_fill_r <= (bpp == BPP_32) ? 2'd0 : width_r[1:0];
    end
    if (blue_we) begin
      blue_r <= byte_data;
    end
    if (green_we) begin
      green_r <= byte_data;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    bip_nxt   = bip_r;
    pad_nxt   = pad_r;
    push      = 1'b0;
    result    = '0;
    hdr_done  = 1'b0;
    pix_do    = 1'b0;
    blue_we   = 1'b0;
    green_we  = 1'b0;

    if (byte_take) begin
      if (sof) begin
        // restart: this byte is byte 0
        pos_nxt = 32'd1;
        col_nxt = '0;
        row_nxt = '0;
        bip_nxt = '0;
        pad_nxt = '0;
        if (byte_data != SIG_B) begin
          push        = 1'b1;
          result.kind = KIND_BAD_SIG;
          phase_nxt   = PH_HALT;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end else begin
        unique case (phase_r)
          PH_WAIT, PH_HALT: begin
          end
          PH_HEADER: begin
            pos_nxt = pos_r + 32'd1;
            if (pos_r == OFS_SIG_M && byte_data != SIG_M) begin
              push        = 1'b1;
              result.kind = KIND_BAD_SIG;
              phase_nxt   = PH_HALT;
            end else if (pos_r == OFS_BPP_HI) begin
              push = 1'b1;
              if (fmt_bad) begin
                result.kind = KIND_UNSUPPORTED;
                phase_nxt   = PH_HALT;
              end else begin
                result.kind   = KIND_HEADER;
                result.width  = DIM_W'(width_r);
                result.height = DIM_W'(height_r);
                hdr_done      = 1'b1;
                phase_nxt     = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            if (pos_r != 32'hFFFF_FFFF) begin
              pos_nxt = pos_r + 32'd1;
            end
            if (pos_r >= ofs_r) begin
              phase_nxt = PH_PIXELS;
              pix_do    = 1'b1;
            end
          end
          PH_PIXELS: pix_do = 1'b1;
          default: phase_nxt = PH_WAIT;
        endcase
      end
    end

    if (pix_do) begin
      if (bip_r == 2'd3) begin
        bip_nxt = 2'd0;                 // alpha byte
      end else if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;         // scanline padding
      end else if (bip_r == 2'd0) begin
        blue_we = 1'b1;
        bip_nxt = 2'd1;
      end else if (bip_r == 2'd1) begin
        green_we = 1'b1;
        bip_nxt  = 2'd2;
      end else begin
        push              = 1'b1;
        result.kind       = KIND_PIXEL;
        result.red        = byte_data;
        result.green      = green_r;
        result.blue       = blue_r;
        result.x_coord    = COORD_W'(col_r);
        result.y_coord    = COORD_W'(y_val);
        result.last_pixel = last;
        bip_nxt           = is32_r ? 2'd3 : 2'd0;
        if (last) begin
          phase_nxt = PH_HALT;
        end else if (col_r == wm1_r) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
          pad_nxt = pad_fill_r;
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/bsd_queue.sv =====
// ----------------------------------------------------------------------------
// bsd_queue
// Back end: two-slot result queue; the head slot drives the result channel.
// ----------------------------------------------------------------------------
module bsd_queue
  import bsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  bsd_result_t push_data,
  output logic        full,
  output logic        head_valid,
  input  logic        head_ready,
  output bsd_result_t head_data
);

  logic [1:0]  cnt_r, cnt_nxt;
  bsd_result_t head_r, tail_r;
  logic        pop;

  assign pop        = head_valid && head_ready;
  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = head_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((cnt_r == 2'd0 && push) || (cnt_r == 2'd1 && push && pop)) begin
      head_r <= push_data;
    end else if (cnt_r == 2'd2 && pop) begin
      head_r <= tail_r;
    end
    if (cnt_r == 2'd1 && push && !pop) begin
      tail_r <= push_data;
    end
  end

endmodule

// ===== rtl/core/bmp_24bit_stream_decoder.sv =====
// A result is registered into the queue at the edge that accepts its byte; out_valid rises right after it if empty.
// Throughput: one file byte per cycle while the queue is not full; the parser updates counters and compares only.
// A two-slot result queue keeps input accepted while the output side stalls briefly.
// Reset (rst_n low at a clock edge) empties the queue and waits for start_of_file.
// ----------------------------------------------------------------------------
// bmp_24bit_stream_decoder
// BMP byte stream to header report and pixel transactions with coordinates.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmp_24bit_stream_decoder
  import bsd_pkg::*;
#(
  parameter int MAX_WIDTH  = BSD_MAX_WIDTH,
  parameter int MAX_HEIGHT = BSD_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_file_byte,
  input  logic               in_start_of_file,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [COORD_W-1:0] out_x_coord,
  output logic [COORD_W-1:0] out_y_coord,
  output logic [DIM_W-1:0]   out_width_out,
  output logic [DIM_W-1:0]   out_height_out,
  output logic               out_last_pixel
);

  logic        byte_take, push, q_full;
  bsd_result_t res, head;

  assign in_ready  = !q_full;
  assign byte_take = in_valid && in_ready;

  bsd_parser #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_take(byte_take),
    .byte_data(in_file_byte),
    .sof      (in_start_of_file),
    .push     (push),
    .result   (res)
  );

  bsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (q_full),
    .head_valid(out_valid),
    .head_ready(out_ready),
    .head_data (head)
  );

  assign out_kind       = head.kind;
  assign out_red        = head.red;
  assign out_green      = head.green;
  assign out_blue       = head.blue;
  assign out_x_coord    = head.x_coord;
  assign out_y_coord    = head.y_coord;
  assign out_width_out  = head.width;
  assign out_height_out = head.height;
  assign out_last_pixel = head.last_pixel;

  `ASSERT_IMP(a_full_has_head, clk, rst_n, !in_ready, out_valid)
  `ASSERT_IMP(a_push_has_room, clk, rst_n, push, in_ready && byte_take)
  `ASSERT_NEXT(a_push_reaches_head, clk, rst_n, push && !out_valid, out_valid)
  `ASSERT_NEXT(a_full_holds, clk, rst_n, !in_ready && !out_ready, !in_ready)

endmodule

// ===== bench/bmp_24bit_stream_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmp_24bit_stream_decoder_tb
// Feeds BMP byte streams through the decoder and checks every result
// transaction against a cycle-free model of the parser kept in a scoreboard.
// Streams: stray bytes, bad signatures, rejected headers, small 24/32-bit
// images with padding and data offsets, cut-off files and the largest sizes.
// ----------------------------------------------------------------------------
module bmp_24bit_stream_decoder_tb;
  import bsd_pkg::*;

  localparam int LONG_HOLD = 150;

  class bmp_decode_tracker;
    bsd_phase_t  phase;
    logic [31:0] pos;
    logic [31:0] data_ofs;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [15:0] bpp;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [1:0]  sub_byte;
    logic [1:0]  pad_left;
    logic [15:0] bg_hold;
    bsd_result_t awaited[$];
    int          errors;

    function new();
      clear();
      phase  = PH_WAIT;
      errors = 0;
    endfunction

    function void clear();
      phase    = PH_WAIT;
      pos      = '0;
      data_ofs = '0;
      img_w    = '0;
      img_h    = '0;
      bpp      = '0;
      col      = '0;
      row      = '0;
      sub_byte = '0;
      pad_left = '0;
      bg_hold  = '0;
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void header_byte(logic [31:0] p, logic [7:0] b);
      bsd_result_t r;
      r = '0;
      if ((p == 32'd0 && b != SIG_B) || (p == OFS_SIG_M && b != SIG_M)) begin
        r.kind = KIND_BAD_SIG;
        awaited = {awaited, r};
        phase = PH_HALT;
        return;
      end
      if (p >= OFS_DATA_LO && p <= OFS_DATA_HI)
        data_ofs |= 32'(b) << (8 * (p - OFS_DATA_LO));
      else if (p >= OFS_WIDTH_LO && p <= OFS_WIDTH_HI)
        img_w |= 32'(b) << (8 * (p - OFS_WIDTH_LO));
      else if (p >= OFS_HGT_LO && p <= OFS_HGT_HI)
        img_h |= 32'(b) << (8 * (p - OFS_HGT_LO));
      else if (p == OFS_BPP_LO)
        bpp[7:0] = b;
      else if (p == OFS_BPP_HI) begin
        bpp[15:8] = b;
        if ((bpp != BPP_24 && bpp != BPP_32) ||
            img_w == 0 || img_w > 32'(BSD_MAX_WIDTH) ||
            img_h == 0 || img_h > 32'(BSD_MAX_HEIGHT) ||
            data_ofs < MIN_DATA_OFS) begin
          r.kind = KIND_UNSUPPORTED;
          phase  = PH_HALT;
        end else begin
          r.kind   = KIND_HEADER;
          r.width  = img_w[DIM_W-1:0];
          r.height = img_h[DIM_W-1:0];
          phase    = PH_SKIP;
        end
        awaited = {awaited, r};
      end
    endfunction

    function void pixel_byte(logic [7:0] b);
      bsd_result_t r;
      logic [31:0] y;
      logic        last;
      // slot 3 is the alpha byte of a 32-bit pixel
      if (sub_byte == 2'd3) begin
        sub_byte = 2'd0;
        return;
      end
      if (pad_left != 0) begin
        pad_left--;
        return;
      end
      if (sub_byte == 2'd0) begin
        bg_hold[7:0] = b;
        sub_byte = 2'd1;
        return;
      end
      if (sub_byte == 2'd1) begin
        bg_hold[15:8] = b;
        sub_byte = 2'd2;
        return;
      end
      y    = img_h - 32'd1 - 32'(row);
      last = (32'(col) == img_w - 32'd1) && (32'(row) == img_h - 32'd1);
      r = '0;
      r.kind       = KIND_PIXEL;
      r.red        = b;
      r.green      = bg_hold[15:8];
      r.blue       = bg_hold[7:0];
      r.x_coord    = col;
      r.y_coord    = y[COORD_W-1:0];
      r.last_pixel = last;
      awaited = {awaited, r};
      sub_byte = (bpp == BPP_32) ? 2'd3 : 2'd0;
      if (last)
        phase = PH_HALT;
      else if (32'(col) == img_w - 32'd1) begin
        col = '0;
        row++;
        // 24-bit rows are padded to 4 bytes: 3*w mod 4 pads by w mod 4
        pad_left = (bpp == BPP_24) ? img_w[1:0] : 2'd0;
      end else
        col++;
    endfunction

    function void note_byte(logic [7:0] b, logic sof);
      logic [31:0] p;
      if (sof) begin
        clear();
        phase = PH_HEADER;
      end
      if (phase == PH_WAIT || phase == PH_HALT) return;
      p = pos;
      if (pos != 32'hFFFF_FFFF) pos++;
      if (phase == PH_HEADER) begin
        header_byte(p, b);
        return;
      end
      if (phase == PH_SKIP) begin
        if (p < data_ofs) return;
        phase = PH_PIXELS;
      end
      pixel_byte(b);
    endfunction

    task cmp_field(string name, logic [DIM_W-1:0] got, logic [DIM_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(bsd_result_t got);
      bsd_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result kind %0d with nothing outstanding", got.kind));
        return;
      end
      want = awaited.pop_front();
      cmp_field("kind", 13'(got.kind), 13'(want.kind));
      cmp_field("red", 13'(got.red), 13'(want.red));
      cmp_field("green", 13'(got.green), 13'(want.green));
      cmp_field("blue", 13'(got.blue), 13'(want.blue));
      cmp_field("x_coord", 13'(got.x_coord), 13'(want.x_coord));
      cmp_field("y_coord", 13'(got.y_coord), 13'(want.y_coord));
      cmp_field("width", got.width, want.width);
      cmp_field("height", got.height, want.height);
      cmp_field("last_pixel", 13'(got.last_pixel), 13'(want.last_pixel));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_file_byte;
  logic               in_start_of_file;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_kind;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic [COORD_W-1:0] out_x_coord;
  logic [COORD_W-1:0] out_y_coord;
  logic [DIM_W-1:0]   out_width_out;
  logic [DIM_W-1:0]   out_height_out;
  logic               out_last_pixel;

  bmp_decode_tracker tracker = new();
  logic [8:0]        byte_plan[$];  // {start_of_file, byte}
  bit                quiet = 1'b0;
  bit                hold_req = 1'b0;
  int                sent_bytes = 0;

  bmp_24bit_stream_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_file_byte     (in_file_byte),
    .in_start_of_file (in_start_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_x_coord      (out_x_coord),
    .out_y_coord      (out_y_coord),
    .out_width_out    (out_width_out),
    .out_height_out   (out_height_out),
    .out_last_pixel   (out_last_pixel)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic void push_raw(logic [7:0] b, logic sof);
    logic [8:0] item;
    item = {sof, b};
    byte_plan = {byte_plan, item};
  endfunction

  function automatic void push_file(logic [31:0] w, logic [31:0] h, logic [15:0] bpp,
                                    logic [31:0] ofs, bit with_data);
    logic [7:0] hdr[30];
    for (int i = 0; i < 30; i++) hdr[i] = 8'($urandom);
    hdr[0] = SIG_B;
    hdr[int'(OFS_SIG_M)] = SIG_M;
    for (int i = 0; i < 4; i++) begin
      hdr[int'(OFS_DATA_LO) + i]  = ofs[8*i +: 8];
      hdr[int'(OFS_WIDTH_LO) + i] = w[8*i +: 8];
      hdr[int'(OFS_HGT_LO) + i]   = h[8*i +: 8];
    end
    hdr[int'(OFS_BPP_LO)] = bpp[7:0];
    hdr[int'(OFS_BPP_HI)] = bpp[15:8];
    for (int i = 0; i < 30; i++) push_raw(hdr[i], i == 0);
    if (!with_data) return;
    for (longint p = 30; p < ofs; p++) push_raw(8'($urandom), 1'b0);
    for (longint r = 0; r < h; r++) begin
      for (longint c = 0; c < w * (int'(bpp) / 8); c++) push_raw(8'($urandom), 1'b0);
      if (bpp == BPP_24)
        for (int k = 0; k < int'(w[1:0]); k++) push_raw(8'($urandom), 1'b0);
    end
    repeat ($urandom_range(0, 3)) push_raw(8'($urandom), 1'b0);
  endfunction

  task automatic send_byte(logic [8:0] item);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_start_of_file <= item[8];
    in_file_byte     <= item[7:0];
    do @(posedge clk); while (!in_ready);
    tracker.note_byte(item[7:0], item[8]);
    sent_bytes++;
  endtask

  task automatic play_plan();
    while (byte_plan.size() != 0) begin
      send_byte(byte_plan[0]);
      void'(byte_plan.pop_front());
    end
  endtask

  task automatic wait_results(int limit);
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    bsd_result_t got;
    stall_left = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rst_n && out_valid && out_ready) begin
        got = {out_kind, out_red, out_green, out_blue, out_x_coord, out_y_coord,
               out_width_out, out_height_out, out_last_pixel};
        tracker.check_result(got);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet)
        stall_left = pick_gap();
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else
        out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int       files;
    int       sel;
    int       cut;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] ofs;
    logic [15:0] bpp;
    logic [7:0]  b;

    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_file_byte     <= 8'h00;
    in_start_of_file <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray bytes before any start, then bad signatures and a cut header
    push_raw(8'hFF, 1'b0);
    push_raw(8'h00, 1'b0);
    push_raw(8'h00, 1'b1);
    push_raw(SIG_M, 1'b0);
    push_raw(SIG_B, 1'b1);
    push_raw(8'hFF, 1'b0);
    push_raw(SIG_B, 1'b1);
    push_raw(SIG_M, 1'b0);
    push_raw(8'hA5, 1'b0);
    // alpha dropped, row padding, far data offset
    push_file(2, 2, BPP_32, 30, 1);
    push_file(3, 2, BPP_24, 40, 1);
    push_file(5, 1, BPP_24, 70, 1);
    // rejected headers
    push_file(2, 2, 16'd16, 30, 0);
    push_file(2, 2, 16'h0118, 30, 0);
    push_file(0, 2, BPP_24, 30, 0);
    push_file(4097, 1, BPP_24, 30, 0);
    push_file(1, 0, BPP_32, 30, 0);
    push_file(1, 32'hFFFF_FFFF, BPP_24, 30, 0);
    push_file(1, 4097, BPP_24, 30, 0);
    push_file(1, 1, BPP_24, 29, 0);
    // accepted header with a huge offset, abandoned by the next start
    push_file(1, 1, BPP_32, 32'h8000_001E, 0);
    play_plan();
    wait_results(5000);
    repeat (4) @(posedge clk);

    // largest sizes accepted, header only, no idling
    quiet = 1'b1;
    push_file(BSD_MAX_WIDTH, BSD_MAX_HEIGHT, BPP_24, 30, 0);
    play_plan();
    quiet = 1'b0;

    files = 0;
    while (sent_bytes < 650 || files == 0) begin
      sel   = (files == 0) ? 0 : $urandom_range(0, 99);
      quiet = (files == 0) || ($urandom_range(0, 5) == 0);
      w   = $urandom_range(1, 6);
      h   = $urandom_range(1, 4);
      bpp = $urandom_range(0, 1) ? BPP_32 : BPP_24;
      ofs = 30 + $urandom_range(0, 6);
      if (files == 0) begin
        w   = 6;
        h   = 4;
        bpp = BPP_32;
      end
      if (sel < 75)
        push_file(w, h, bpp, ofs, 1);
      else if (sel < 85) begin
        // file cut off before its end
        push_file(w, h, bpp, ofs, 1);
        cut = $urandom_range(1, byte_plan.size() - 1);
        while (byte_plan.size() > cut) void'(byte_plan.pop_back());
      end else if (sel < 95) begin
        case ($urandom_range(0, 5))
          0: begin
            b = 8'($urandom);
            if (b == SIG_B) b ^= 8'h01;
            push_raw(b, 1'b1);
          end
          1: begin
            b = 8'($urandom);
            if (b == SIG_M) b ^= 8'h01;
            push_raw(SIG_B, 1'b1);
            push_raw(b, 1'b0);
          end
          2: push_file(w, h, 16'($urandom), ofs, 0);
          3: push_file($urandom_range(0, 1) ? $urandom : $urandom_range(4090, 4200),
                       h, bpp, ofs, 0);
          4: push_file(w, $urandom, bpp, ofs, 0);
          default: push_file(w, h, bpp, $urandom_range(0, 35), 0);
        endcase
        repeat ($urandom_range(0, 3)) push_raw(8'($urandom), 1'b0);
      end else
        repeat ($urandom_range(1, 6)) push_raw(8'($urandom), 1'b0);
      // long receiver hold-off while bytes keep coming
      if (files == 0) hold_req = 1'b1;
      play_plan();
      if (files == 0) begin
        wait_results(5000);
        repeat (3) @(posedge clk);
      end
      files++;
    end
    quiet = 1'b0;

    wait_results(20000);
    repeat (16) @(posedge clk);
    while (tracker.awaited.size() != 0) begin
      tracker.report($sformatf("result kind %0d never arrived", tracker.awaited[0].kind));
      void'(tracker.awaited.pop_front());
    end
    if (tracker.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TIMEOUT @%0t", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule
